// ===== rtl/gsva_pkg.sv =====
// types and constants for the gene-structure add-compare-select core
// no dependencies
package gsva_pkg;
  localparam int NUM_STATES = 17;
  localparam int NUM_COSTS  = 11;
  localparam int LANE_W     = 16;
  localparam int CHOICE_W   = 25;
  localparam int EXON_W     = 3;
  localparam int OUTX_W     = 32;

  localparam logic [2:0] BASE_A = 3'd0;
  localparam logic [2:0] BASE_G = 3'd2;
  localparam logic [2:0] BASE_T = 3'd3;

  localparam int S_E = 0, S_F = 1, S_H = 2, S_G = 3, S_A = 4, S_B = 5, S_I = 6, S_J = 7,
                 S_T = 8, S_K = 9, S_L = 10, S_M = 11, S_X = 12, S_5 = 13, S_3 = 14,
                 S_U = 15, S_V = 16;

  // base pattern gates decided in the front stage
  typedef struct packed {
    logic rna3;
    logic t2;
    logic ta;
    logic tg;
    logic b3_a;
    logic b3_g;
    logic last;
  } gsva_class_t;
endpackage

// ===== rtl/gsva_front.sv =====
// front stage: unpacks costs and classifies the base pattern of one beat
// depends on gsva_pkg
module gsva_front import gsva_pkg::*; #(
  parameter int COST_WIDTH = 16
) (
  input  logic [63:0]                        in_costs_low,
  input  logic [63:0]                        in_costs_mid,
  input  logic [47:0]                        in_costs_high,
  input  logic [11:0]                        in_base_codes,
  input  logic                               in_last_position,
  output logic [NUM_COSTS-1:0][COST_WIDTH-1:0] costs,
  output gsva_class_t                        cls
);
  logic [2:0] b1, b2, b3, b4;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      costs[i]     = in_costs_low[i*LANE_W +: COST_WIDTH];
      costs[4 + i] = in_costs_mid[i*LANE_W +: COST_WIDTH];
    end
    for (int i = 0; i < 3; i++) begin
      costs[8 + i] = in_costs_high[i*LANE_W +: COST_WIDTH];
    end
  end

  assign b1 = in_base_codes[2:0];
  assign b2 = in_base_codes[5:3];
  assign b3 = in_base_codes[8:6];
  assign b4 = in_base_codes[11:9];

  assign cls.rna3 = (b3 == BASE_A && b4 == BASE_A) || (b3 == BASE_A && b4 == BASE_G) ||
                    (b3 == BASE_G && b4 == BASE_A);
  assign cls.t2   = (b2 == BASE_T);
  assign cls.ta   = (b1 == BASE_T) && (b2 == BASE_A);
  assign cls.tg   = (b1 == BASE_T) && (b2 == BASE_G);
  assign cls.b3_a = (b3 == BASE_A);
  assign cls.b3_g = (b3 == BASE_G);
  assign cls.last = in_last_position;
endmodule

// ===== rtl/gsva_queue.sv =====
// two-entry queue between front and back stage
// depends on gsva_pkg
module gsva_queue import gsva_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  logic [1:0][W-1:0] mem_r;
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= ~wp_r;
      if (do_rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !wr_ready) else $error("full queue accepted");
  a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !rd_valid) else $error("empty queue valid");
endmodule

// ===== rtl/gsva_back.sv =====
// back stage: add-compare-select over the 17 state scores, registered result
// depends on gsva_pkg
module gsva_back import gsva_pkg::*; #(
  parameter int COST_WIDTH  = 16,
  parameter int SCORE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  logic [NUM_COSTS-1:0][COST_WIDTH-1:0] costs,
  input  gsva_class_t                          cls,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [CHOICE_W-1:0]                  out_choice_word,
  output logic [EXON_W-1:0]                    out_exon_pick,
  output logic [OUTX_W-1:0]                    out_score_x,
  output logic                                 out_sequence_end
);
  localparam logic [SCORE_WIDTH-1:0] SMAX = '1;

  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0] s_r;
  logic [NUM_STATES-1:0][SCORE_WIDTH-1:0] n;
  logic [NUM_STATES-1:0][1:0] p;
  logic [SCORE_WIDTH-1:0] mx;
  logic [EXON_W-1:0] ex;
  logic fire;

  function automatic logic [SCORE_WIDTH-1:0] sat(input logic [SCORE_WIDTH-1:0] a,
                                                 input logic [COST_WIDTH-1:0] c);
    logic [SCORE_WIDTH:0] s;
    s = {1'b0, a} + {{(SCORE_WIDTH + 1 - COST_WIDTH){1'b0}}, c};
    sat = s[SCORE_WIDTH] ? SMAX : s[SCORE_WIDTH-1:0];
  endfunction

  assign q_ready = !out_valid || out_ready;
  assign fire    = q_valid && q_ready;

  always_comb begin
    logic [SCORE_WIDTH-1:0] cd;
    logic ok [6];
    n = s_r;
    p = '0;
    cd = '0;
    mx = s_r[S_E];
    ex = '0;
    for (int i = 1; i < 6; i++) begin
      if (s_r[i] < mx) begin
        mx = s_r[i];
        ex = EXON_W'(i);
      end
    end
    // E
    n[S_E] = sat(s_r[S_E], costs[0]);
    cd = sat(s_r[S_X], costs[0]); if (cd < n[S_E]) begin n[S_E] = cd; p[S_E] = 2'd1; end
    cd = sat(s_r[S_I], costs[0]); if (cd < n[S_E]) begin n[S_E] = cd; p[S_E] = 2'd2; end
    cd = sat(s_r[S_5], costs[0]); if (cd < n[S_E]) begin n[S_E] = cd; p[S_E] = 2'd3; end
    // F, H
    n[S_F] = sat(s_r[S_F], costs[1]);
    cd = sat(s_r[S_J], costs[1]);
    if (!cls.rna3 && cd < n[S_F]) begin n[S_F] = cd; p[S_F] = 2'd1; end
    cd = sat(s_r[S_T], costs[1]);
    if (!cls.rna3 && cd < n[S_F]) begin n[S_F] = cd; p[S_F] = 2'd2; end
    n[S_H] = sat(s_r[S_H], costs[1]);
    cd = sat(s_r[S_J], costs[1]);
    if (cls.rna3 && cd < n[S_H]) begin n[S_H] = cd; p[S_H] = 2'd1; end
    // G, A, B
    n[S_G] = sat(s_r[S_G], costs[2]);
    cd = sat(s_r[S_K], costs[2]);
    if (!cls.b3_a && !cls.b3_g && cd < n[S_G]) begin n[S_G] = cd; p[S_G] = 2'd1; end
    cd = sat(s_r[S_L], costs[2]);
    if (!cls.b3_a && !cls.b3_g && cd < n[S_G]) begin n[S_G] = cd; p[S_G] = 2'd2; end
    cd = sat(s_r[S_M], costs[2]);
    if (!cls.b3_a && !cls.b3_g && cd < n[S_G]) begin n[S_G] = cd; p[S_G] = 2'd3; end
    n[S_A] = sat(s_r[S_A], costs[2]);
    cd = sat(s_r[S_K], costs[2]);
    if (cls.b3_a && cd < n[S_A]) begin n[S_A] = cd; p[S_A] = 2'd1; end
    n[S_B] = sat(s_r[S_B], costs[2]);
    cd = sat(s_r[S_K], costs[2]);
    if (cls.b3_g && cd < n[S_B]) begin n[S_B] = cd; p[S_B] = 2'd1; end
    cd = sat(s_r[S_M], costs[2]);
    if (cls.b3_g && cd < n[S_B]) begin n[S_B] = cd; p[S_B] = 2'd2; end
    // single-source states from the exon minimum
    ok[0] = 1'b1;
    ok[1] = !cls.t2;
    ok[2] = cls.t2;
    ok[3] = !cls.ta && !cls.tg;
    ok[4] = cls.ta;
    ok[5] = cls.tg;
    for (int i = 0; i < 6; i++) begin
      if (ok[i] && mx < s_r[S_I + i]) begin
        n[S_I + i] = sat(mx, costs[(i == 0) ? 3 : ((i < 3) ? 4 : 5)]);
        p[S_I + i] = 2'd1;
      end else begin
        n[S_I + i] = sat(s_r[S_I + i], costs[(i == 0) ? 3 : ((i < 3) ? 4 : 5)]);
      end
    end
    // X, 5, 3
    n[S_X] = sat(s_r[S_X], costs[6]);
    cd = sat(mx, costs[6]); if (cd < n[S_X]) begin n[S_X] = cd; p[S_X] = 2'd1; end
    cd = sat(s_r[S_3], costs[6]); if (cd < n[S_X]) begin n[S_X] = cd; p[S_X] = 2'd2; end
    n[S_5] = sat(s_r[S_5], costs[7]);
    cd = sat(s_r[S_X], costs[7]); if (cd < n[S_5]) begin n[S_5] = cd; p[S_5] = 2'd1; end
    cd = sat(s_r[S_U], costs[7]); if (cd < n[S_5]) begin n[S_5] = cd; p[S_5] = 2'd2; end
    n[S_3] = sat(s_r[S_3], costs[8]);
    cd = sat(mx, costs[8]); if (cd < n[S_3]) begin n[S_3] = cd; p[S_3] = 2'd1; end
    cd = sat(s_r[S_V], costs[8]); if (cd < n[S_3]) begin n[S_3] = cd; p[S_3] = 2'd2; end
    // U, V
    if (s_r[S_5] < s_r[S_U]) begin
      n[S_U] = sat(s_r[S_5], costs[9]); p[S_U] = 2'd1;
    end else begin
      n[S_U] = sat(s_r[S_U], costs[9]);
    end
    if (s_r[S_3] < s_r[S_V]) begin
      n[S_V] = sat(s_r[S_3], costs[10]); p[S_V] = 2'd1;
    end else begin
      n[S_V] = sat(s_r[S_V], costs[10]);
    end
  end

  logic [CHOICE_W-1:0] word;
  logic [OUTX_W-1:0] xclamp;
  assign word = {1'b0, p[S_V][0], p[S_U][0], p[S_3], p[S_5], p[S_X], p[S_M][0], p[S_L][0],
                 p[S_K][0], p[S_T][0], p[S_J][0], p[S_I][0], p[S_B], p[S_A][0], p[S_G],
                 p[S_H][0], p[S_F], p[S_E]};

  always_comb begin
    if (SCORE_WIDTH > OUTX_W) begin
      xclamp = (n[S_X] > SCORE_WIDTH'({OUTX_W{1'b1}})) ? '1 : OUTX_W'(n[S_X]);
    end else begin
      xclamp = OUTX_W'(n[S_X]);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_choice_word  <= word;
      out_exon_pick    <= ex;
      out_score_x      <= xclamp;
      out_sequence_end <= cls.last;
    end
    if (!rst_n) begin
      s_r       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        s_r <= cls.last ? '0 : n;
      end
      if (fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cls.last |=> s_r == '0) else $error("scores not cleared");
  a_exon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_exon_pick < 3'd6) else $error("bad exon pick");
  a_bit24: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_choice_word[24]) else $error("top choice bit set");
endmodule

// ===== rtl/gene_structure_viterbi_acs_core.sv =====
// Gene-structure add-compare-select core: one sequence position per beat, one result
// per beat. The front unpacks costs and base gates into a two-entry queue; the back
// updates all 17 saturating scores combinationally and registers the result. The
// sustained rate is one position per clock while the output is not stalled. A result
// passes through the queue entry and then the result register before it is valid, and
// an output stall holds it there; the queue keeps the input open until both entries
// fill while the result register waits. Scores clear to zero after a beat marked
// last. Depends on gsva_pkg and the gsva_* modules.
module gene_structure_viterbi_acs_core import gsva_pkg::*; #(
  parameter int COST_WIDTH  = 16,
  parameter int SCORE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [63:0]         in_costs_low,
  input  logic [63:0]         in_costs_mid,
  input  logic [47:0]         in_costs_high,
  input  logic [11:0]         in_base_codes,
  input  logic                in_last_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHOICE_W-1:0] out_choice_word,
  output logic [EXON_W-1:0]   out_exon_pick,
  output logic [OUTX_W-1:0]   out_score_x,
  output logic                out_sequence_end
);
  localparam int QW = NUM_COSTS * COST_WIDTH + $bits(gsva_class_t);

  logic [NUM_COSTS-1:0][COST_WIDTH-1:0] f_costs, b_costs;
  gsva_class_t f_cls, b_cls;
  logic q_valid, q_ready;

  gsva_front #(.COST_WIDTH(COST_WIDTH)) u_front (
    .in_costs_low(in_costs_low), .in_costs_mid(in_costs_mid),
    .in_costs_high(in_costs_high), .in_base_codes(in_base_codes),
    .in_last_position(in_last_position), .costs(f_costs), .cls(f_cls)
  );

  gsva_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data({f_costs, f_cls}),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data({b_costs, b_cls})
  );

  gsva_back #(.COST_WIDTH(COST_WIDTH), .SCORE_WIDTH(SCORE_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
    .costs(b_costs), .cls(b_cls),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_choice_word(out_choice_word), .out_exon_pick(out_exon_pick),
    .out_score_x(out_score_x), .out_sequence_end(out_sequence_end)
  );
endmodule
